### rtl/core/iraf_pkg.sv
// Package for the IPv4 range access filter.
// Holds operation codes, rule type bits and the stored rule record.
// No dependencies.
package iraf_pkg;

  // operation codes
  localparam logic [1:0] OP_CHECK     = 2'd0;
  localparam logic [1:0] OP_ADD       = 2'd1;
  localparam logic [1:0] OP_CLEAR_ONE = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

  // rule type bit positions and the pure-log code
  localparam int unsigned TYPE_ALLOW_BIT = 0;
  localparam int unsigned TYPE_LOG_BIT   = 2;
  localparam int unsigned TYPE_SOFT_BIT  = 3;
  localparam logic [3:0]  TYPE_LOG_ONLY  = 4'd4;

  localparam int unsigned OCTET_W = 8;

  // one stored rule
  typedef struct packed {
    logic [3:0]  rtype;
    logic [31:0] low;
    logic [31:0] high;
  } rule_t;

endpackage

### rtl/core/ip_range_access_filter_top.sv
// An add writes the rule and the set count, a clear drops set-present bits; a check visits each
// set in turn, scans each present set's rules and falls back to the soft verdict; a busy output stalls.
// One item at a time; while scanning a set, one rule per cycle through the registered rule read port.
// Reset clears the set-present bits, the sequencer and the output valid; the rule and count
// memories are not cleared, an absent set reads as holding no rules.
// Top level of the IPv4 range access filter; depends on iraf_pkg.
module ip_range_access_filter_top
  import iraf_pkg::*;
#(
  parameter int unsigned NUM_SETS      = 8,
  parameter int unsigned RULES_PER_SET = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  set_id_i,
  input  logic [3:0]  rule_type_i,
  input  logic [31:0] low_octets_i,
  input  logic [31:0] high_octets_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        allowed_o,
  output logic        log_request_o
);

  localparam int unsigned SLOTS = NUM_SETS * RULES_PER_SET;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SETW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SCW   = $clog2(NUM_SETS + 1);
  localparam int unsigned CW    = $clog2(RULES_PER_SET + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADD     = 3'd1;
  localparam logic [2:0] S_CK_SET  = 3'd2;
  localparam logic [2:0] S_CK_CNT  = 3'd3;
  localparam logic [2:0] S_CK_RULE = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  // per-octet inclusive range test
  function automatic logic octets_match(input logic [31:0] a, input logic [31:0] lo,
                                        input logic [31:0] hi);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (a[k*OCTET_W +: OCTET_W] < lo[k*OCTET_W +: OCTET_W] ||
          a[k*OCTET_W +: OCTET_W] > hi[k*OCTET_W +: OCTET_W]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [NUM_SETS-1:0] present_q, present_d;
  logic [SCW-1:0]      scan_q, scan_d;
  logic [SW-1:0]       base_q, base_d;
  logic [SW-1:0]       rptr_q, rptr_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                verdict_q, verdict_d;
  logic                logacc_q, logacc_d;
  logic                res_status_q, res_status_d;
  logic                res_allowed_q, res_allowed_d;
  logic                res_log_q, res_log_d;
  logic                out_valid_q, out_valid_d;
  logic                status_q, allowed_q, log_q;

  // latched item fields
  logic [2:0]  set_q;
  logic [3:0]  type_q;
  logic [31:0] low_q, high_q, addr_q;

  // memories
  rule_t         rule_mem [SLOTS];
  logic [CW-1:0] cnt_mem  [NUM_SETS];
  rule_t         rule_rd_q;
  logic [CW-1:0] cnt_rd_q;

  logic          rule_re, rule_we;
  logic [SW-1:0] rule_raddr, rule_waddr;
  logic          cnt_re, cnt_we;
  logic [SETW-1:0] cnt_raddr, cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  logic            in_xfer;
  logic [SETW-1:0] in_set_idx, set_idx;
  logic            in_set_ok, set_ok;
  logic            in_present, set_present;
  logic [CW-1:0]   cur_cnt;
  logic            hit;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign allowed_o     = allowed_q;
  assign log_request_o = log_q;

  // set number checks for the incoming and the latched item
  assign in_set_idx  = SETW'(set_id_i);
  assign in_set_ok   = 32'(set_id_i) < NUM_SETS;
  assign in_present  = in_set_ok ? present_q[in_set_idx] : 1'b0;
  assign set_idx     = SETW'(set_q);
  assign set_ok      = 32'(set_q) < NUM_SETS;
  assign set_present = set_ok ? present_q[set_idx] : 1'b0;
  assign cur_cnt     = set_present ? cnt_rd_q : '0;
  assign hit         = octets_match(addr_q, rule_rd_q.low, rule_rd_q.high);

  // sequencer
  always_comb begin
    state_d       = state_q;
    present_d     = present_q;
    scan_d        = scan_q;
    base_d        = base_q;
    rptr_d        = rptr_q;
    idx_d         = idx_q;
    verdict_d     = verdict_q;
    logacc_d      = logacc_q;
    res_status_d  = res_status_q;
    res_allowed_d = res_allowed_q;
    res_log_d     = res_log_q;
    out_valid_d   = out_valid_q;
    rule_re       = 1'b0;
    rule_raddr    = rptr_q;
    rule_we       = 1'b0;
    rule_waddr    = SW'(32'(set_idx) * RULES_PER_SET) + SW'(cur_cnt);
    cnt_re        = 1'b0;
    cnt_raddr     = in_set_idx;
    cnt_we        = 1'b0;
    cnt_waddr     = set_idx;
    cnt_wdata     = cur_cnt + CW'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        cnt_re = 1'b1;
        if (in_xfer) begin
          res_status_d  = 1'b0;
          res_allowed_d = 1'b0;
          res_log_d     = 1'b0;
          case (operation_i)
            OP_CHECK: begin
              scan_d    = '0;
              base_d    = '0;
              verdict_d = 1'b1;
              logacc_d  = 1'b0;
              state_d   = S_CK_SET;
            end
            OP_ADD: begin
              state_d = S_ADD;
            end
            OP_CLEAR_ONE: begin
              if (!in_present) begin
                res_status_d = 1'b1;
              end else begin
                present_d[in_set_idx] = 1'b0;
              end
              state_d = S_FIN;
            end
            default: begin
              present_d = '0;
              state_d   = S_FIN;
            end
          endcase
        end
      end

      // append the rule if the set has room
      S_ADD: begin
        if (!set_ok || cur_cnt >= CW'(RULES_PER_SET)) begin
          res_status_d = 1'b1;
        end else begin
          rule_we            = 1'b1;
          cnt_we             = 1'b1;
          present_d[set_idx] = 1'b1;
        end
        state_d = S_FIN;
      end

      // next present set, or the default verdict after the last one
      S_CK_SET: begin
        if (scan_q == SCW'(NUM_SETS)) begin
          res_allowed_d = verdict_q;
          res_log_d     = logacc_q;
          state_d       = S_FIN;
        end else if (!present_q[SETW'(scan_q)]) begin
          scan_d = scan_q + SCW'(1);
          base_d = base_q + SW'(RULES_PER_SET);
        end else begin
          cnt_re    = 1'b1;
          cnt_raddr = SETW'(scan_q);
          state_d   = S_CK_CNT;
        end
      end

      // skip an empty set, else start reading the first rule of the set
      S_CK_CNT: begin
        if (cnt_rd_q == '0) begin
          scan_d  = scan_q + SCW'(1);
          base_d  = base_q + SW'(RULES_PER_SET);
          state_d = S_CK_SET;
        end else begin
          rule_re    = 1'b1;
          rule_raddr = base_q;
          rptr_d     = base_q;
          idx_d      = '0;
          state_d    = S_CK_RULE;
        end
      end

      // evaluate one rule while the next one is fetched
      S_CK_RULE: begin
        if (hit && rule_rd_q.rtype != TYPE_LOG_ONLY && !rule_rd_q.rtype[TYPE_SOFT_BIT]) begin
          res_allowed_d = rule_rd_q.rtype[TYPE_ALLOW_BIT];
          res_log_d     = logacc_q | rule_rd_q.rtype[TYPE_LOG_BIT];
          state_d       = S_FIN;
        end else begin
          if (hit && rule_rd_q.rtype == TYPE_LOG_ONLY) begin
            logacc_d = 1'b1;
          end else if (hit) begin
            verdict_d = rule_rd_q.rtype[TYPE_ALLOW_BIT];
            logacc_d  = logacc_q | rule_rd_q.rtype[TYPE_LOG_BIT];
          end
          if (idx_q + CW'(1) < cnt_rd_q) begin
            rule_re    = 1'b1;
            rule_raddr = rptr_q + SW'(1);
            rptr_d     = rptr_q + SW'(1);
            idx_d      = idx_q + CW'(1);
          end else begin
            scan_d  = scan_q + SCW'(1);
            base_d  = base_q + SW'(RULES_PER_SET);
            state_d = S_CK_SET;
          end
        end
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scan and result payload registers
  always_ff @(posedge clk_i) begin
    scan_q        <= scan_d;
    base_q        <= base_d;
    rptr_q        <= rptr_d;
    idx_q         <= idx_d;
    verdict_q     <= verdict_d;
    logacc_q      <= logacc_d;
    res_status_q  <= res_status_d;
    res_allowed_q <= res_allowed_d;
    res_log_q     <= res_log_d;
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      status_q  <= res_status_q;
      allowed_q <= res_allowed_q;
      log_q     <= res_log_q;
    end
    if (in_xfer) begin
      set_q  <= set_id_i;
      type_q <= rule_type_i;
      low_q  <= low_octets_i;
      high_q <= high_octets_i;
      addr_q <= address_i;
    end
  end

  // rule memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (rule_we) begin
      rule_mem[rule_waddr] <= '{rtype: type_q, low: low_q, high: high_q};
    end
    if (rule_re) begin
      rule_rd_q <= rule_mem[rule_raddr];
    end
  end

  // per-set rule count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

endmodule
